/* sv/rtcbcd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rtcbcd_pkg
// Types, constants and conversion functions shared by the time word / BCD
// register converter.
// ----------------------------------------------------------------------------
package rtcbcd_pkg;

  typedef enum logic {
    CMD_SET  = 1'b0,
    CMD_READ = 1'b1
  } cmd_t;

  localparam logic [7:0] SEC_TENS_MASK   = 8'h70;
  localparam logic [7:0] MIN_TENS_MASK   = 8'h70;
  localparam logic [7:0] HOUR_TENS_MASK  = 8'h30;
  localparam logic [7:0] DAY_TENS_MASK   = 8'h30;
  localparam logic [7:0] MONTH_TENS_MASK = 8'h10;
  localparam logic [7:0] YEAR_TENS_MASK  = 8'hF0;

  localparam logic [27:0] MS_PER_HOUR = 28'd3600000;
  localparam logic [27:0] MS_PER_MIN  = 28'd60000;
  localparam logic [27:0] MS_PER_SEC  = 28'd1000;

  // Input word, last field in the lowest bits.
  typedef struct packed {
    logic [7:0]  bcd_year;
    logic [7:0]  bcd_month;
    logic [7:0]  bcd_day;
    logic [7:0]  bcd_weekday;
    logic [7:0]  bcd_hour;
    logic [7:0]  bcd_minute;
    logic [7:0]  bcd_second;
    logic [31:0] packed_time_in;
  } in_item_t;

  // Result word, last field in the lowest bits.
  typedef struct packed {
    logic [55:0] bcd_word;
    logic [27:0] ms_in_day;
    logic [31:0] packed_time_out;
    logic [2:0]  weekday;
    logic [7:0]  year_bin;
    logic [4:0]  month_bin;
    logic [5:0]  day_bin;
    logic [5:0]  hour_bin;
    logic [6:0]  minute_bin;
    logic [6:0]  second_bin;
  } result_t;

  function automatic logic [7:0] to_bcd(input logic [5:0] v);
    logic [13:0] prod;
    logic [2:0]  tens;
    logic [5:0]  ones;
    prod = 14'(v) * 14'd205;
    tens = prod[13:11];
    ones = v - 6'(tens) * 6'd10;
    return {1'b0, tens, ones[3:0]};
  endfunction

  function automatic logic [7:0] from_bcd(input logic [7:0] b, input logic [7:0] mask);
    logic [7:0] masked;
    logic [7:0] tens;
    masked = b & mask;
    tens   = {4'b0, masked[7:4]};
    return {4'b0, b[3:0]} + (tens << 3) + (tens << 1);
  endfunction

  // Whole part of 31 * m / 12.
  function automatic logic [5:0] month_term(input logic [3:0] m);
    logic [5:0] t;
    case (m)
      4'd1:    t = 6'd2;
      4'd2:    t = 6'd5;
      4'd3:    t = 6'd7;
      4'd4:    t = 6'd10;
      4'd5:    t = 6'd12;
      4'd6:    t = 6'd15;
      4'd7:    t = 6'd18;
      4'd8:    t = 6'd20;
      4'd9:    t = 6'd23;
      4'd10:   t = 6'd25;
      4'd11:   t = 6'd28;
      4'd12:   t = 6'd31;
      4'd13:   t = 6'd33;
      4'd14:   t = 6'd36;
      4'd15:   t = 6'd38;
      default: t = 6'd0;
    endcase
    return t;
  endfunction

  // Gregorian day of week. With a two-digit year the century terms vanish,
  // and year zero in January or February leaves a year of minus one.
  function automatic logic [2:0] day_of_week(input logic [4:0] day, input logic [3:0] month,
                                             input logic [5:0] year);
    logic        early;
    logic        neg;
    logic [3:0]  m;
    logic [5:0]  yv;
    logic [7:0]  sum;
    logic [14:0] prod;
    logic [5:0]  q;
    logic [7:0]  r;
    early = (month <= 4'd2);
    neg   = early && (year == 6'd0);
    m     = early ? month + 4'd10 : month - 4'd2;
    yv    = neg ? 6'd0 : year - 6'(early);
    sum   = 8'(day) + 8'(yv) + 8'(yv[5:2]) + 8'(month_term(m)) - 8'(neg);
    prod  = 15'(sum) * 15'd73;
    q     = prod[14:9];
    r     = sum - 8'(q) * 8'd7;
    if (r >= 8'd7) begin
      r = r - 8'd7;
    end
    return r[2:0];
  endfunction

endpackage
`default_nettype wire

/* sv/rtcbcd_conv.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rtcbcd_conv
// Conversion logic between the packed time word and the BCD clock bytes.
// ----------------------------------------------------------------------------
module rtcbcd_conv
  import rtcbcd_pkg::*;
(
  input  wire logic     cmd,
  input  wire in_item_t item,
  output result_t       res
);

  logic [6:0]  sec;
  logic [6:0]  min;
  logic [5:0]  hour;
  logic [5:0]  day;
  logic [4:0]  month;
  logic [7:0]  year;
  logic [7:0]  d_sec;
  logic [7:0]  d_min;
  logic [7:0]  d_hour;
  logic [7:0]  d_day;
  logic [7:0]  d_month;
  logic [7:0]  d_year;
  logic [2:0]  dow;
  logic [31:0] repacked;
  logic [31:0] p;

  assign p = item.packed_time_in;

  always_comb begin
    d_sec    = from_bcd(item.bcd_second, SEC_TENS_MASK);
    d_min    = from_bcd(item.bcd_minute, MIN_TENS_MASK);
    d_hour   = from_bcd(item.bcd_hour, HOUR_TENS_MASK);
    d_day    = from_bcd(item.bcd_day, DAY_TENS_MASK);
    d_month  = from_bcd(item.bcd_month, MONTH_TENS_MASK);
    d_year   = from_bcd(item.bcd_year, YEAR_TENS_MASK);
    dow      = day_of_week(p[31:27], p[26:23], p[22:17]);
    repacked = (32'(d_day) << 27) + (32'(d_month) << 23) + (32'(d_year) << 17)
             + (32'(d_hour) << 12) + (32'(d_min) << 6) + 32'(d_sec);

    if (cmd == CMD_SET) begin
      sec   = 7'(p[5:0]);
      min   = 7'(p[11:6]);
      hour  = 6'(p[16:12]);
      year  = 8'(p[22:17]);
      month = 5'(p[26:23]);
      day   = 6'(p[31:27]);
      res.weekday         = dow;
      res.packed_time_out = p;
      res.bcd_word        = {to_bcd(p[22:17]), to_bcd(2'b0 + 6'(p[26:23])),
                             to_bcd(6'(p[31:27])), 5'b0, dow,
                             to_bcd(6'(p[16:12])), to_bcd(p[11:6]), to_bcd(p[5:0])};
    end else begin
      sec   = d_sec[6:0];
      min   = d_min[6:0];
      hour  = d_hour[5:0];
      year  = d_year;
      month = d_month[4:0];
      day   = d_day[5:0];
      res.weekday         = item.bcd_weekday[2:0];
      res.packed_time_out = repacked;
      res.bcd_word        = 56'd0;
    end

    res.second_bin = sec;
    res.minute_bin = min;
    res.hour_bin   = hour;
    res.day_bin    = day;
    res.month_bin  = month;
    res.year_bin   = year;
    res.ms_in_day  = 28'(hour) * MS_PER_HOUR + 28'(min) * MS_PER_MIN + 28'(sec) * MS_PER_SEC;
  end

endmodule
`default_nettype wire

/* sv/rtc_time_bcd_converter.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rtc_time_bcd_converter
// Converts a packed time word into BCD clock bytes with the day of week, or
// decodes BCD clock bytes into a packed time word.
//
//   Channel  Direction  Word                          Handshake
//   in_      slave      tdata 88 bits, tuser command   tvalid / tready
//   out_     master     tdata 160 bits                 tvalid / tready
//
// One word is taken every cycle while in_tready is high; each word passes
// through an input register and a result register around the conversion
// logic. Reset clears both valid flags. When the result is held back, the
// input register keeps one more word before in_tready falls.
// ----------------------------------------------------------------------------
module rtc_time_bcd_converter
  import rtcbcd_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // packed_time_in, bcd_second, bcd_minute, bcd_hour, bcd_weekday, bcd_day,
  // bcd_month, bcd_year
  input  wire logic [87:0]  in_tdata,
  // command
  input  wire logic         in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // second_bin, minute_bin, hour_bin, day_bin, month_bin, year_bin, weekday,
  // packed_time_out, ms_in_day, bcd_word, two zero bits
  output logic [159:0]      out_tdata
);

  logic     s1_valid_r;
  logic     s1_valid_nxt;
  logic     s1_cmd_r;
  in_item_t s1_item_r;
  logic     out_valid_r;
  logic     out_valid_nxt;
  result_t  out_res_r;
  result_t  conv_res;
  logic     s1_adv;
  logic     in_acc;

  rtcbcd_conv u_conv (
    .cmd  (s1_cmd_r),
    .item (s1_item_r),
    .res  (conv_res)
  );

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt  = in_acc || (s1_valid_r && !s1_adv);
    out_valid_nxt = s1_adv || (out_valid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r  <= in_tuser;
      s1_item_r <= in_item_t'(in_tdata);
    end
    if (s1_adv) begin
      out_res_r <= conv_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b0, out_res_r};

  a_accept_loads : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_valid_r)
    else $error("accepted word did not reach the input register");

  a_hold_stalled : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_item_r) && $stable(s1_cmd_r)))
    else $error("stalled word in the input register was lost or changed");

  a_advance_shows : assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("converted word did not reach the result register");

  a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !s1_adv)
    else $error("held result overwritten");

endmodule
`default_nettype wire

/* test/rtc_time_bcd_converter_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_time_bcd_converter_tb
// Drives set and read words through the time converter with random gaps and
// back-pressure, predicts every result word from the input word alone and
// compares each field of the result stream in order.
// ----------------------------------------------------------------------------
module rtc_time_bcd_converter_tb
  import rtcbcd_pkg::*;
();

  localparam int unsigned N_RANDOM     = 1880;
  localparam int unsigned BURST_FIRST  = 380;
  localparam int unsigned BURST_LAST   = 700;
  localparam int unsigned HOLD_AT      = 450;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned DRAIN_AT     = 1000;
  localparam int unsigned IDLE_LIMIT   = 1000;
  localparam int unsigned TAIL_CYCLES  = 8;

  typedef struct {
    cmd_t        cmd;
    in_item_t    data;
    int unsigned gap;
    bit          drain;
  } stim_word_t;

  logic         clk;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [87:0]  in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [159:0] out_tdata;

  stim_word_t  stim_q[$];
  result_t     expected_q[$];
  int unsigned pending = 0;
  int unsigned words_in = 0;
  int          fail_cnt = 0;

  rtc_time_bcd_converter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [7:0] bcd_byte(int unsigned v);
    return 8'(((v / 10) << 4) + (v % 10));
  endfunction

  function automatic int unsigned bcd_value(logic [7:0] b, logic [7:0] tens_mask);
    logic [7:0] t;
    t = b & tens_mask;
    return int'(b[3:0]) + int'(t[7:4]) * 10;
  endfunction

  function automatic int unsigned week_day(int d, int mo, int yr);
    int a, y, m, s;
    a = (14 - mo) / 12;
    y = yr - a;
    m = mo + 12 * a - 2;
    s = 7000 + d + y + y / 4 - y / 100 + y / 400 + (31 * m) / 12;
    return s % 7;
  endfunction

  function automatic result_t convert_time(cmd_t cmd, in_item_t w);
    result_t     r;
    int unsigned sec, mn, hr, dy, mo, yr, dow;
    logic [31:0] pk, ms;
    logic [55:0] bcd;
    bcd = '0;
    if (cmd == CMD_SET) begin
      pk  = w.packed_time_in;
      sec = 32'(pk[5:0]);
      mn  = 32'(pk[11:6]);
      hr  = 32'(pk[16:12]);
      yr  = 32'(pk[22:17]);
      mo  = 32'(pk[26:23]);
      dy  = 32'(pk[31:27]);
      dow = week_day(dy, mo, yr);
      bcd = {bcd_byte(yr), bcd_byte(mo), bcd_byte(dy), 8'(dow),
             bcd_byte(hr), bcd_byte(mn), bcd_byte(sec)};
    end else begin
      sec = bcd_value(w.bcd_second, SEC_TENS_MASK);
      mn  = bcd_value(w.bcd_minute, MIN_TENS_MASK);
      hr  = bcd_value(w.bcd_hour, HOUR_TENS_MASK);
      dy  = bcd_value(w.bcd_day, DAY_TENS_MASK);
      mo  = bcd_value(w.bcd_month, MONTH_TENS_MASK);
      yr  = bcd_value(w.bcd_year, YEAR_TENS_MASK);
      dow = 32'(w.bcd_weekday[2:0]);
      pk  = (dy << 27) + (mo << 23) + (yr << 17) + (hr << 12) + (mn << 6) + sec;
    end
    ms = hr * MS_PER_HOUR + mn * MS_PER_MIN + sec * MS_PER_SEC;
    r.second_bin      = 7'(sec);
    r.minute_bin      = 7'(mn);
    r.hour_bin        = 6'(hr);
    r.day_bin         = 6'(dy);
    r.month_bin       = 5'(mo);
    r.year_bin        = 8'(yr);
    r.weekday         = 3'(dow);
    r.packed_time_out = pk;
    r.ms_in_day       = ms[27:0];
    r.bcd_word        = bcd;
    return r;
  endfunction

  function automatic logic [31:0] time_word(int unsigned dd, int unsigned mo, int unsigned yy,
                                            int unsigned hh, int unsigned mi, int unsigned ss);
    return 32'((dd << 27) | (mo << 23) | (yy << 17) | (hh << 12) | (mi << 6) | ss);
  endfunction

  function automatic in_item_t set_item(logic [31:0] pk);
    in_item_t it;
    it = in_item_t'(88'({$urandom(), $urandom(), $urandom()}));
    it.packed_time_in = pk;
    return it;
  endfunction

  function automatic in_item_t read_item(logic [7:0] s, logic [7:0] mi, logic [7:0] h,
                                         logic [7:0] wd, logic [7:0] d, logic [7:0] mo,
                                         logic [7:0] y);
    in_item_t it;
    it.packed_time_in = $urandom();
    it.bcd_second     = s;
    it.bcd_minute     = mi;
    it.bcd_hour       = h;
    it.bcd_weekday    = wd;
    it.bcd_day        = d;
    it.bcd_month      = mo;
    it.bcd_year       = y;
    return it;
  endfunction

  task automatic queue_word(cmd_t c, in_item_t it, int unsigned gap, bit drain);
    stim_word_t s;
    s.cmd   = c;
    s.data  = it;
    s.gap   = gap;
    s.drain = drain;
    stim_q.push_back(s);
  endtask

  function automatic int unsigned pick_gap(int unsigned mode);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (mode == 0 || r < 60) begin
      return 0;
    end else if (mode == 1 || r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_cnt++;
    end
  endtask

  // Stimulus: directed words first, then the random stream.
  initial begin
    int unsigned mode, gap, k;
    in_item_t    it;
    cmd_t        c;
    mode = 0;
    queue_word(CMD_SET, set_item(32'h0000_0000), 0, 1'b0);
    queue_word(CMD_SET, set_item(32'hFFFF_FFFF), 0, 1'b0);
    queue_word(CMD_SET, set_item(time_word(1, 1, 0, 0, 0, 0)), 0, 1'b0);
    queue_word(CMD_SET, set_item(time_word(29, 2, 0, 23, 59, 59)), 1, 1'b0);
    queue_word(CMD_SET, set_item(time_word(31, 15, 63, 0, 0, 0)), 0, 1'b0);
    queue_word(CMD_SET, set_item(time_word(15, 3, 24, 12, 34, 56)), 0, 1'b0);
    queue_word(CMD_SET, set_item(time_word(0, 0, 0, 31, 63, 63)), 2, 1'b0);
    queue_word(CMD_SET, set_item(time_word(31, 12, 63, 23, 59, 59)), 0, 1'b0);
    queue_word(CMD_SET, set_item(time_word(1, 1, 1, 0, 0, 0)), 0, 1'b0);
    queue_word(CMD_SET, set_item(time_word(13, 13, 5, 7, 8, 9)), 0, 1'b0);
    queue_word(CMD_SET, set_item(time_word(14, 14, 0, 1, 2, 3)), 0, 1'b0);
    queue_word(CMD_SET, set_item(time_word(28, 2, 4, 6, 30, 0)), 0, 1'b0);
    queue_word(CMD_READ, read_item(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 0, 1'b0);
    queue_word(CMD_READ, read_item(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 0, 1'b0);
    queue_word(CMD_READ, read_item(8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F), 3, 1'b0);
    queue_word(CMD_READ, read_item(8'h59, 8'h59, 8'h23, 8'h06, 8'h31, 8'h12, 8'h99), 0, 1'b0);
    queue_word(CMD_READ, read_item(8'h00, 8'h00, 8'h00, 8'h07, 8'h01, 8'h01, 8'h00), 0, 1'b0);
    queue_word(CMD_READ, read_item(8'h12, 8'h34, 8'h08, 8'hF8, 8'h15, 8'h09, 8'h24), 0, 1'b0);
    queue_word(CMD_READ, read_item(8'h5A, 8'hA5, 8'h3F, 8'h03, 8'h3F, 8'h1F, 8'hFA), 0, 1'b0);
    queue_word(CMD_READ, read_item(8'hAA, 8'hBB, 8'hCC, 8'hDD, 8'hEE, 8'hFF, 8'h11), 0, 1'b0);
    queue_word(CMD_SET, set_item(time_word(1, 2, 0, 0, 0, 1)), 0, 1'b0);

    for (int unsigned i = 0; i < N_RANDOM; i++) begin
      if (i % 100 == 0) begin
        mode = $urandom_range(0, 2);
      end
      gap = (i >= BURST_FIRST && i < BURST_LAST) ? 0 : pick_gap(mode);
      k = $urandom_range(0, 99);
      if (k < 40) begin
        c  = CMD_SET;
        it = set_item(time_word($urandom_range(1, 31), $urandom_range(1, 12),
                                $urandom_range(0, 63), $urandom_range(0, 23),
                                $urandom_range(0, 59), $urandom_range(0, 59)));
      end else if (k < 60) begin
        c  = CMD_SET;
        it = set_item($urandom());
      end else if (k < 85) begin
        c  = CMD_READ;
        it = read_item(bcd_byte($urandom_range(0, 59)), bcd_byte($urandom_range(0, 59)),
                       bcd_byte($urandom_range(0, 23)), 8'($urandom_range(0, 6)),
                       bcd_byte($urandom_range(1, 31)), bcd_byte($urandom_range(1, 12)),
                       bcd_byte($urandom_range(0, 99)));
      end else begin
        c  = CMD_READ;
        it = read_item(8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()),
                       8'($urandom()), 8'($urandom()), 8'($urandom()));
      end
      queue_word(c, it, gap, i == 0 || i == DRAIN_AT);
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (stim_q.size() != 0 || in_tvalid || pending != 0) begin
      @(negedge clk);
    end
    repeat (TAIL_CYCLES) @(negedge clk);
    if (expected_q.size() != 0) begin
      $error("%0d result words never arrived", expected_q.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Sender. A word flagged for draining is held back until every result is in.
  int unsigned tx_gap = 0;
  int unsigned tx_busy;
  bit          tx_took;
  stim_word_t  tx_next;

  always @(posedge clk) begin
    if (rst_n) begin
      tx_took = in_tvalid && in_tready;
      tx_busy = pending + int'(tx_took) - int'(out_tvalid && out_tready);
      if (in_tvalid && !tx_took) begin
        // keep offering the same word
      end else if (tx_gap > 0) begin
        tx_gap--;
        in_tvalid <= 1'b0;
      end else if (stim_q.size() != 0 && !(stim_q[0].drain && tx_busy != 0)) begin
        tx_next = stim_q.pop_front();
        in_tdata  <= tx_next.data;
        in_tuser  <= tx_next.cmd;
        in_tvalid <= 1'b1;
        tx_gap = tx_next.gap;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver, with one long hold-off while the sender keeps offering words.
  int unsigned rx_stall = 0;
  int unsigned rx_phase_left = 0;
  int unsigned rx_roll;
  bit          rx_calm = 1'b0;
  bit          rx_hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst_n) begin
      if (rx_phase_left == 0) begin
        rx_calm = ($urandom_range(0, 3) == 0);
        rx_phase_left = 128;
      end
      rx_phase_left--;
      if (!rx_hold_done && words_in >= HOLD_AT) begin
        rx_hold_done = 1'b1;
        rx_stall = HOLD_CYCLES;
      end
      if (rx_stall > 0) begin
        rx_stall--;
        out_tready <= 1'b0;
      end else if (rx_calm) begin
        out_tready <= 1'b1;
      end else begin
        rx_roll = $urandom_range(0, 99);
        if (rx_roll < 70) begin
          out_tready <= 1'b1;
        end else begin
          rx_stall = (rx_roll < 92) ? $urandom_range(0, 2) : $urandom_range(9, 29);
          out_tready <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result word, then records the prediction for a new input word.
  result_t got_res, want_res;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got_res = result_t'(out_tdata[157:0]);
        if (expected_q.size() == 0) begin
          $error("result word 0x%0h arrived with nothing expected", out_tdata);
          fail_cnt++;
        end else begin
          want_res = expected_q.pop_front();
          check_field("second_bin", 64'(want_res.second_bin), 64'(got_res.second_bin));
          check_field("minute_bin", 64'(want_res.minute_bin), 64'(got_res.minute_bin));
          check_field("hour_bin", 64'(want_res.hour_bin), 64'(got_res.hour_bin));
          check_field("day_bin", 64'(want_res.day_bin), 64'(got_res.day_bin));
          check_field("month_bin", 64'(want_res.month_bin), 64'(got_res.month_bin));
          check_field("year_bin", 64'(want_res.year_bin), 64'(got_res.year_bin));
          check_field("weekday", 64'(want_res.weekday), 64'(got_res.weekday));
          check_field("packed_time_out", 64'(want_res.packed_time_out),
                      64'(got_res.packed_time_out));
          check_field("ms_in_day", 64'(want_res.ms_in_day), 64'(got_res.ms_in_day));
          check_field("bcd_word", 64'(want_res.bcd_word), 64'(got_res.bcd_word));
        end
      end
      if (in_tvalid && in_tready) begin
        expected_q.push_back(convert_time(cmd_t'(in_tuser), in_item_t'(in_tdata)));
        words_in <= words_in + 1;
      end
      pending <= expected_q.size();
    end
  end

  int unsigned idle_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

endmodule
